>>> design/rtc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rtc_pkg: shared types, constants and functions of the radix-64 text codec
// Holds the channel payload structs, the job descriptor that links the front
// and back parts, and the alphabet conversions.
// ============================================================================
`default_nettype none

package rtc_pkg;

    // Configuration mode codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Job queue geometry
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Error latched in the drop count
    localparam logic [1:0] DROP_ERR = 2'd3;

    // Bytes to drop from the final group, indexed by length remainder
    localparam logic [1:0] DROP_FOR_REM [4] = '{2'd0, 2'd2, 2'd1, 2'd0};

    // Alphabet anchor characters
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_DASH    = 8'h2d;
    localparam logic [7:0] CH_UNDER   = 8'h5f;

    // Symbol values at the alphabet section boundaries
    localparam logic [5:0] VAL_UPPER = 6'd26;
    localparam logic [5:0] VAL_DIGIT = 6'd52;
    localparam logic [5:0] VAL_ZERO  = 6'd61;
    localparam logic [5:0] VAL_DASH  = 6'd62;

    typedef struct packed {
        logic [7:0] data_in;
        logic       first_item;
        logic       last_item;
        logic [1:0] length_remainder;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic       bad_symbol;
    } out_item_t;

    // One unit of work for the back part; every job yields at least one result
    typedef struct packed {
        logic        enc;     // encode job, else decode job
        logic        hdr;     // encode: header symbol goes first
        logic [1:0]  rem;     // encode: header symbol value
        logic        grp_en;  // encode: four group symbols follow
        logic [23:0] grp;     // packed group
        logic [1:0]  cnt;     // decode: bytes to send (1..3)
        logic        trunc;   // decode: truncated group, one error result
        logic        bad;     // decode: error flag for the bytes
    } job_t;

    // Symbol value 0..63 to its character
    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] c;
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < VAL_UPPER) begin
            c = CH_LOWER_A + v8;
        end else if (v < VAL_DIGIT) begin
            c = CH_UPPER_A + v8 - {2'b00, VAL_UPPER};
        end else if (v < VAL_ZERO) begin
            c = CH_ONE + v8 - {2'b00, VAL_DIGIT};
        end else if (v == VAL_ZERO) begin
            c = CH_ZERO;
        end else if (v == VAL_DASH) begin
            c = CH_DASH;
        end else begin
            c = CH_UNDER;
        end
        return c;
    endfunction

    // Character to {known, value}; unknown characters give value 0
    function automatic logic [6:0] sym_decode(input logic [7:0] ch);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'h00;
        r = 7'h00;
        if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            d = ch - CH_LOWER_A;
            r = {1'b1, d[5:0]};
        end else if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            d = ch - CH_UPPER_A + {2'b00, VAL_UPPER};
            r = {1'b1, d[5:0]};
        end else if (ch inside {[CH_ONE:CH_NINE]}) begin
            d = ch - CH_ONE + {2'b00, VAL_DIGIT};
            r = {1'b1, d[5:0]};
        end else if (ch == CH_ZERO) begin
            r = {1'b1, VAL_ZERO};
        end else if (ch == CH_DASH) begin
            r = {1'b1, VAL_DASH};
        end else if (ch == CH_UNDER) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/rtc_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rtc_front: input side of the radix-64 text codec
// Accepts items, keeps the group state and the mode, and turns each item
// into at most one job for the back part.
// ============================================================================
`default_nettype none

module rtc_front import rtc_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cfg_valid,
    input  wire logic     cfg_mode,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    input  wire logic     q_full,
    output logic          push,
    output job_t          job
);

    logic        mode_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [23:0] acc_reg, acc_next;
    logic [1:0]  drop_reg, drop_next;

    logic        accept;
    logic        job_ok;
    logic [6:0]  dec;
    logic [5:0]  sval;
    logic [1:0]  phase_base;
    logic [23:0] acc_base;
    logic [23:0] acc_new;
    logic [1:0]  drop_upd;
    logic        flush;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && job_ok;

    always_comb begin
        dec        = sym_decode(s_item.data_in);
        sval       = dec[5:0];
        phase_next = phase_reg;
        acc_next   = acc_reg;
        drop_next  = drop_reg;
        job_ok     = 1'b0;
        job        = '0;
        phase_base = phase_reg;
        acc_base   = acc_reg;
        acc_new    = acc_reg;
        drop_upd   = drop_reg;
        flush      = 1'b0;

        if (mode_reg == MODE_ENCODE) begin
            // restart the group on a header or a stale full group
            if (s_item.first_item || phase_reg > 2'd2) begin
                phase_base = 2'd0;
                acc_base   = 24'h0;
            end
            case (phase_base)
                2'd0:    acc_new = acc_base | {s_item.data_in, 16'h0};
                2'd1:    acc_new = acc_base | {8'h0, s_item.data_in, 8'h0};
                default: acc_new = acc_base | {16'h0, s_item.data_in};
            endcase
            flush      = (phase_base == 2'd2) || s_item.last_item;
            job.enc    = 1'b1;
            job.hdr    = s_item.first_item;
            job.rem    = s_item.length_remainder;
            job.grp_en = flush;
            job.grp    = acc_new;
            job_ok     = s_item.first_item || flush;
            phase_next = flush ? 2'd0 : phase_base + 2'd1;
            acc_next   = flush ? 24'h0 : acc_new;
        end else if (s_item.first_item) begin
            // header: set the drop count, no results
            phase_next = 2'd0;
            acc_next   = 24'h0;
            drop_next  = dec[6] ? DROP_FOR_REM[sval[1:0]] : DROP_ERR;
        end else begin
            drop_upd = dec[6] ? drop_reg : DROP_ERR;
            case (phase_reg)
                2'd0:    acc_new = acc_reg | {sval, 18'h0};
                2'd1:    acc_new = acc_reg | {6'h0, sval, 12'h0};
                2'd2:    acc_new = acc_reg | {12'h0, sval, 6'h0};
                default: acc_new = acc_reg | {18'h0, sval};
            endcase
            drop_next = drop_upd;
            job.grp   = acc_new;
            job.bad   = (drop_upd == DROP_ERR);
            job.cnt   = (s_item.last_item && drop_upd != DROP_ERR) ?
                        2'd3 - drop_upd : 2'd3;
            if (phase_reg == 2'd3) begin
                job_ok     = 1'b1;
                phase_next = 2'd0;
                acc_next   = 24'h0;
            end else if (s_item.last_item) begin
                job_ok     = 1'b1;
                job.trunc  = 1'b1;
                phase_next = 2'd0;
                acc_next   = 24'h0;
            end else begin
                phase_next = phase_reg + 2'd1;
                acc_next   = acc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ENCODE;
            phase_reg <= 2'd0;
            acc_reg   <= 24'h0;
            drop_reg  <= 2'd0;
        end else if (cfg_valid) begin
            // mode write clears all group state
            mode_reg  <= cfg_mode;
            phase_reg <= 2'd0;
            acc_reg   <= 24'h0;
            drop_reg  <= 2'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

`default_nettype wire

>>> design/rtc_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// rtc_queue: job queue between front and back
// Two-entry register queue; the head is visible without a read cycle.
// ============================================================================
`default_nettype none

module rtc_queue import rtc_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      empty,
    output logic      full
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/rtc_back.sv
`timescale 1ns / 1ps
// ============================================================================
// rtc_back: result side of the radix-64 text codec
// Steps through the head job one result per cycle into the output register, unless m_ready stalls it.
// ============================================================================
`default_nettype none

module rtc_back import rtc_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire job_t head,
    input  wire logic empty,
    output logic      pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_item
);

    logic [2:0] step_reg;
    logic       m_valid_reg;
    out_item_t  m_item_reg;

    logic       advance;
    logic       res_last;
    out_item_t  res;
    logic [2:0] j3;
    logic [1:0] j;
    logic [5:0] sym;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign advance = !empty && (!m_valid_reg || m_ready);
    assign pop     = advance && res_last;

    always_comb begin
        j3       = step_reg - {2'b00, head.hdr};
        j        = j3[1:0];
        res      = '0;
        res_last = 1'b0;
        case (j)
            2'd0:    sym = head.grp[23:18];
            2'd1:    sym = head.grp[17:12];
            2'd2:    sym = head.grp[11:6];
            default: sym = head.grp[5:0];
        endcase
        if (head.enc) begin
            if (head.hdr && step_reg == 3'd0) begin
                res.data_out = sym_char({4'h0, head.rem});
                res_last     = !head.grp_en;
            end else begin
                res.data_out = sym_char(sym);
                res_last     = (j == 2'd3);
            end
        end else if (head.trunc) begin
            res.bad_symbol = 1'b1;
            res_last       = 1'b1;
        end else begin
            case (step_reg[1:0])
                2'd0:    res.data_out = head.grp[23:16];
                2'd1:    res.data_out = head.grp[15:8];
                default: res.data_out = head.grp[7:0];
            endcase
            res.bad_symbol = head.bad;
            res_last       = (step_reg[1:0] == head.cnt - 2'd1);
        end
        res.last_out = res_last;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_item_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg <= 1'b1;
                step_reg    <= res_last ? 3'd0 : step_reg + 3'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/radix64_text_codec.sv
`timescale 1ns / 1ps
// ============================================================================
// radix64_text_codec: length-prefixed radix-64 text encoder and decoder
// Encodes bytes into symbols of the alphabet a-z A-Z 1-9 0 - _ with a
// leading length header, or decodes such symbols back into bytes.
// ============================================================================
//
//  Channel | Ports                        | Payload     | Direction
//  --------+------------------------------+-------------+----------
//  input   | s_valid  s_ready  s_item     | in_item_t   | in
//  result  | m_valid  m_ready  m_item     | out_item_t  | out
//  config  | cfg_valid cfg_ready cfg_mode | mode bit    | in
//
//  An input item is taken whenever the two-entry job queue has room, so
//  items may arrive back to back. The back part sends one result per cycle
//  from the queue head unless m_ready stalls it; that single output port
//  sets throughput: an encode group of three bytes gives four results (five
//  with a header), a decode group of four symbols up to three. Results pass
//  a queue slot, then the output register. Reset (aresetn low, synchronous)
//  empties the queue and clears mode and group state; no clearing pass is
//  needed. Stalls on m_ready fill the queue and then drop s_ready.
//
`default_nettype none

module radix64_text_codec import rtc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    // configuration write
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_mode,
    // input items
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    // result items
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    job_t push_job;
    job_t head_job;

    // Register writes must come only while idle (the block does not enforce it), so take them at once
    assign cfg_ready = 1'b1;

    // Front: classify each item and update the group state
    rtc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_mode  (cfg_mode),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    // Queue: decouple the item rate from the result rate
    rtc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Back: expand each job into results, one transfer per cycle unless m_ready stalls
    rtc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head_job),
        .empty   (q_empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

>>> design/rtc_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// rtc_checker: port-level checks for the radix-64 text codec
// Watches the top-level ports and is bound to every instance of the codec.
// ============================================================================
`default_nettype none

module rtc_checker import rtc_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    // Hold a stalled result
    a_m_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    a_m_item_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_item))
        else $error("m_item changed while stalled");

    // A run continues without a gap once a non-last result transfers
    a_run_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item.last_out |=> m_valid)
        else $error("gap inside a result run");

    // Reset leaves no result pending and the input open
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state left after reset");

endmodule

bind radix64_text_codec rtc_checker u_rtc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

>>> tb/sv/tb_radix64_text_codec.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_radix64_text_codec: self-checking bench for the radix-64 text codec
// Sends byte messages through the encoder and symbol messages through the
// decoder. A cycle-free predictor computes the results for every input
// transfer, and each result transfer is compared field by field, in order.
// ============================================================================

module tb_radix64_text_codec;
    import rtc_pkg::*;

    // Bench constants
    localparam int SETTLE_CYCLES = 12;      // covers the path through queue slot and output register with margin
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int MAX_REPORTS   = 50;
    localparam int SEGMENT_ITEMS = 52;

    // Value 0 is the leftmost character
    localparam logic [8*64-1:0] ALPHABET =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890-_";

    // Clock, reset and DUT ports; every input starts at a known value
    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_mode  = MODE_ENCODE;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_item    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_item;

    // Stimulus and scoreboard state
    in_item_t  items_to_send[$];
    out_item_t outputs_due[$];
    logic      s_taken       = 1'b0;
    int        cfg_writes    = 0;
    int        queued_items  = 0;
    int        outputs_seen  = 0;
    int        mismatch_count = 0;
    int        send_idle_pct = 15;
    int        recv_idle_pct = 88;

    // Predictor state, mirrors the block after reset
    logic        codec_mode = MODE_ENCODE;
    int          group_fill = 0;
    logic [23:0] group_acc  = '0;
    logic [1:0]  drop_bytes = 2'd0;

    radix64_text_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_mode  (cfg_mode),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Alphabet helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] symbol_char(int v);
        return ALPHABET[8*(63 - v) +: 8];
    endfunction

    // Position in the alphabet, or -1 for a character outside it
    function automatic int symbol_value(logic [7:0] ch);
        for (int k = 0; k < 64; k++) begin
            if (symbol_char(k) == ch) return k;
        end
        return -1;
    endfunction

    // Any character the decoder must reject
    function automatic logic [7:0] foreign_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(255));
        while (symbol_value(ch) >= 0) ch = 8'($urandom_range(255));
        return ch;
    endfunction

    function automatic out_item_t make_output(logic [7:0] data, logic bad);
        out_item_t o;
        o.data_out   = data;
        o.last_out   = 1'b0;
        o.bad_symbol = bad;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: turn one accepted input transfer into its output run
    // ------------------------------------------------------------------
    function automatic void encode_or_decode(in_item_t it);
        out_item_t run[$];
        int        v;
        int        count;
        logic      bad;
        if (codec_mode == MODE_ENCODE) begin
            // Header symbol leads the message, then pack bytes MSB first
            if (it.first_item) begin
                group_fill = 0;
                group_acc  = '0;
                run.push_back(make_output(symbol_char(int'(it.length_remainder)), 1'b0));
            end
            if (group_fill > 2) begin
                group_fill = 0;
                group_acc  = '0;
            end
            group_acc  = group_acc | (24'(it.data_in) << (16 - 8 * group_fill));
            group_fill = group_fill + 1;
            if (group_fill == 3 || it.last_item) begin
                for (int k = 0; k < 4; k++) begin
                    run.push_back(make_output(symbol_char(int'(group_acc[18 - 6*k +: 6])),
                                              1'b0));
                end
                group_fill = 0;
                group_acc  = '0;
            end
        end else begin
            v = symbol_value(it.data_in);
            // Header: pick the trailing drop, or latch the error; no output
            if (it.first_item) begin
                group_fill = 0;
                group_acc  = '0;
                if (v < 0) begin
                    drop_bytes = DROP_ERR;
                end else begin
                    case (v % 4)
                        1:       drop_bytes = 2'd2;
                        2:       drop_bytes = 2'd1;
                        default: drop_bytes = 2'd0;
                    endcase
                end
                return;
            end
            // Unknown data symbol counts as zero and latches the error
            if (v < 0) begin
                drop_bytes = DROP_ERR;
                v = 0;
            end
            group_acc  = group_acc | (24'(v) << (18 - 6 * group_fill));
            group_fill = group_fill + 1;
            if (group_fill == 4) begin
                bad   = (drop_bytes == DROP_ERR);
                count = 3;
                if (it.last_item && !bad) count = count - int'(drop_bytes);
                for (int k = 0; k < count; k++) begin
                    run.push_back(make_output(group_acc[16 - 8*k +: 8], bad));
                end
                group_fill = 0;
                group_acc  = '0;
            end else if (it.last_item) begin
                // Truncated final group: one flagged zero, then discard
                run.push_back(make_output(8'h00, 1'b1));
                group_fill = 0;
                group_acc  = '0;
            end
        end
        if (run.size() > 0) run[run.size() - 1].last_out = 1'b1;
        foreach (run[k]) outputs_due.push_back(run[k]);
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string msg);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] output %0d: %s", $time, outputs_seen, msg);
    endtask

    task automatic compare_output(out_item_t got);
        out_item_t want;
        if (outputs_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected transfer, data_out 0x%02h", got.data_out));
            return;
        end
        want = outputs_due.pop_front();
        if (got.data_out !== want.data_out)
            flag_mismatch($sformatf("data_out 0x%02h, want 0x%02h",
                                    got.data_out, want.data_out));
        if (got.last_out !== want.last_out)
            flag_mismatch($sformatf("last_out %b, want %b", got.last_out, want.last_out));
        if (got.bad_symbol !== want.bad_symbol)
            flag_mismatch($sformatf("bad_symbol %b, want %b",
                                    got.bad_symbol, want.bad_symbol));
    endtask

    // Monitor: sample every handshake at the rising edge, in transfer order.
    // A mode write always lands on a drained block, so its order against
    // input transfers in the same cycle never matters.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                // A mode write also clears the group and the latched error
                codec_mode = cfg_mode;
                group_fill = 0;
                group_acc  = '0;
                drop_bytes = 2'd0;
                cfg_writes <= cfg_writes + 1;
            end
            if (s_valid && s_ready) encode_or_decode(s_item);
            if (m_valid && m_ready) begin
                compare_output(m_item);
                outputs_seen = outputs_seen + 1;
            end
        end
    end

    // Driver: hold the current item until its transfer, then advance or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_item  <= items_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(logic [7:0] data, logic first, logic last, logic [1:0] rem);
        in_item_t it;
        it.data_in          = data;
        it.first_item       = first;
        it.last_item        = last;
        it.length_remainder = rem;
        items_to_send.push_back(it);
        queued_items = queued_items + 1;
    endtask

    // Hold until every queued item is sent and every output has come back
    task automatic wait_until_drained();
        while (items_to_send.size() != 0 || s_valid || outputs_due.size() != 0)
            @(posedge aclk);
    endtask

    // Write the mode only on an idle block; a decode header leaves no output,
    // so let the pipeline settle after the last output before the write
    task automatic write_mode(logic m);
        int seen;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_mode  <= m;
        wait (cfg_writes != seen);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_encode_message(int len);
        for (int i = 0; i < len; i++) begin
            push_item(8'($urandom_range(255)), i == 0, i == len - 1,
                      (i == 0) ? 2'(len % 3) : 2'($urandom_range(3)));
        end
    endtask

    // Header for remainder rem, then n_sym symbols; position corrupt_at
    // (0 is the header) gets a foreign character, -1 leaves all valid
    task automatic add_decode_message(int n_sym, int rem, int corrupt_at);
        logic [7:0] ch;
        ch = symbol_char(rem + 4 * $urandom_range(15));
        if (corrupt_at == 0) ch = foreign_char();
        push_item(ch, 1'b1, n_sym == 0, 2'($urandom_range(3)));
        for (int k = 1; k <= n_sym; k++) begin
            ch = (k == corrupt_at) ? foreign_char() : symbol_char($urandom_range(63));
            push_item(ch, 1'b0, k == n_sym, 2'($urandom_range(3)));
        end
    endtask

    task automatic random_encode(int count);
        int stop;
        int pick;
        stop = queued_items + count;
        while (queued_items < stop) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                // Mostly short messages, now and then a longer one
                add_encode_message(($urandom_range(9) == 0) ? $urandom_range(30, 12)
                                                            : $urandom_range(8, 1));
            end else if (pick < 88) begin
                // Continue without a header
                push_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                          2'($urandom_range(3)));
            end else begin
                push_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 2'($urandom_range(3)));
            end
        end
    endtask

    task automatic random_decode(int count);
        int stop;
        int pick;
        int n;
        stop = queued_items + count;
        while (queued_items < stop) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                add_decode_message(4 * $urandom_range(3, 1), $urandom_range(2), -1);
            end else if (pick < 75) begin
                n = 4 * $urandom_range(2, 1);
                add_decode_message(n, $urandom_range(2), $urandom_range(n));
            end else if (pick < 85) begin
                // Final group cut short
                add_decode_message(4 * $urandom_range(2) + $urandom_range(3, 1),
                                   $urandom_range(2), -1);
            end else if (pick < 90) begin
                add_decode_message(0, $urandom_range(3), -1);
            end else begin
                push_item($urandom_range(1) ? symbol_char($urandom_range(63))
                                            : 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          2'($urandom_range(3)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int profile;
        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed encode cases
        write_mode(MODE_ENCODE);
        push_item(8'h00, 1'b1, 1'b1, 2'd1);         // single zero byte
        push_item(8'hff, 1'b1, 1'b1, 2'd3);         // remainder three in the header
        push_item(8'hff, 1'b1, 1'b0, 2'd0);         // full group, split by a drain
        push_item(8'h00, 1'b0, 1'b0, 2'd0);
        wait_until_drained();                        // sender pauses mid-message
        push_item(8'ha5, 1'b0, 1'b0, 2'd0);
        push_item(8'h5a, 1'b0, 1'b0, 2'd2);         // continue without a header
        push_item(8'hc3, 1'b0, 1'b1, 2'd1);

        // Directed decode cases
        write_mode(MODE_DECODE);
        push_item("d", 1'b1, 1'b0, 2'd0);           // remainder three drops nothing
        push_item("_", 1'b0, 1'b0, 2'd0);
        push_item("-", 1'b0, 1'b0, 2'd0);
        push_item("0", 1'b0, 1'b0, 2'd0);
        push_item("Z", 1'b0, 1'b1, 2'd0);
        push_item(8'hff, 1'b1, 1'b0, 2'd3);         // unknown header latches the error
        push_item("a", 1'b0, 1'b0, 2'd0);
        push_item("b", 1'b0, 1'b0, 2'd0);
        push_item("9", 1'b0, 1'b0, 2'd0);
        push_item("z", 1'b0, 1'b1, 2'd0);
        push_item("a", 1'b1, 1'b0, 2'd0);           // clean header clears the error
        push_item("A", 1'b0, 1'b0, 2'd0);
        push_item(8'h80, 1'b0, 1'b0, 2'd0);         // unknown data symbol
        push_item("1", 1'b0, 1'b0, 2'd0);
        push_item(8'h00, 1'b0, 1'b0, 2'd0);
        push_item("x", 1'b0, 1'b1, 2'd0);           // truncated final group
        push_item("c", 1'b1, 1'b1, 2'd2);           // header that is also last

        // Random traffic under three idle profiles
        for (profile = 0; profile < 3; profile++) begin
            case (profile)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_mode(MODE_ENCODE);
            random_encode(SEGMENT_ITEMS);
            write_mode(MODE_DECODE);
            random_decode(SEGMENT_ITEMS);
        end

        // Drain, then watch a little longer for stray outputs
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d outputs outstanding", outputs_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
design/rtc_pkg.sv
design/rtc_front.sv
design/rtc_queue.sv
design/rtc_back.sv
design/radix64_text_codec.sv
design/rtc_checker.sv
tb/sv/tb_radix64_text_codec.sv
